### hdl/i2cm_pkg.sv
// Package for the I2C master bit engine: item types, command codes, slot
// constants and the engine state record. No dependencies.
package i2cm_pkg;

    // Command codes carried in the op field
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Position inside one bit cell (three slots per data bit)
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    localparam int SLOT_W = 5;

    // Slot landmarks of the byte sequences
    localparam logic [SLOT_W-1:0] SLOT_FIRST    = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_ONE      = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_TWO      = 5'd2;
    localparam logic [SLOT_W-1:0] SLOT_COND_END = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_BITS_END = 5'd24;
    localparam logic [SLOT_W-1:0] SLOT_RELEASE  = 5'd25;
    localparam logic [SLOT_W-1:0] SLOT_ACK_A    = 5'd26;
    localparam logic [SLOT_W-1:0] SLOT_ACK_B    = 5'd27;
    localparam logic [SLOT_W-1:0] SLOT_ACK_C    = 5'd28;

    // Kind codes
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // One input item
    typedef struct packed {
        logic       kind;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       give_ack;
        logic       sda_in;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } t_res_item;

    // Engine state carried between items
    typedef struct packed {
        t_op               operation;
        logic [SLOT_W-1:0] slot;
        t_phase            phase;
        logic              active;
        logic [7:0]        shift_byte;
        logic              ack_choice;
        logic              ack_bit;
        logic              clock_level;
        logic              data_level;
        logic [7:0]        rx_hold;
    } t_state;

endpackage

### hdl/i2cm_if.sv
// Valid/ready channels of the I2C master bit engine.
// Depends on i2cm_pkg for the item types.
interface i2cm_in_if;
    logic                valid;
    logic                ready;
    i2cm_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
    logic                valid;
    logic                ready;
    i2cm_pkg::t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/i2cm_step.sv
// Next-state logic of the I2C master bit engine: one item against the
// current state gives the next state and the result item. Uses i2cm_pkg.
module i2cm_step (
    input  i2cm_pkg::t_state    i_state,
    input  i2cm_pkg::t_in_item  i_item,
    output i2cm_pkg::t_state    o_state,
    output i2cm_pkg::t_res_item o_res
);

    i2cm_pkg::t_state n_state;
    logic             n_last;
    logic             n_done;
    logic             n_rej;

    always_comb begin
        n_state = i_state;
        n_last  = 1'b0;
        n_done  = 1'b0;
        n_rej   = 1'b0;

        if (i_item.kind == i2cm_pkg::KIND_CMD) begin
            // command: drop while busy, else load a new sequence
            if (i_state.active) begin
                n_rej = 1'b1;
            end else begin
                n_state.operation  = i2cm_pkg::t_op'(i_item.op);
                n_state.shift_byte = i_item.tx_byte;
                n_state.ack_choice = i_item.give_ack;
                n_state.slot       = i2cm_pkg::SLOT_FIRST;
                n_state.phase      = i2cm_pkg::PH_FIRST;
                n_state.active     = 1'b1;
            end
        end else if (i_state.active) begin
            // tick: apply the pin state of the current slot
            unique case (i_state.operation)
                i2cm_pkg::OP_START: begin
                    if (i_state.slot == i2cm_pkg::SLOT_FIRST) n_state.data_level = 1'b1;
                    else if (i_state.slot == i2cm_pkg::SLOT_ONE) n_state.clock_level = 1'b1;
                    else if (i_state.slot == i2cm_pkg::SLOT_TWO) n_state.data_level = 1'b0;
                    else n_state.clock_level = 1'b0;
                    n_last = (i_state.slot >= i2cm_pkg::SLOT_COND_END);
                end
                i2cm_pkg::OP_STOP: begin
                    if (i_state.slot == i2cm_pkg::SLOT_FIRST) n_state.clock_level = 1'b0;
                    else if (i_state.slot == i2cm_pkg::SLOT_ONE) n_state.data_level = 1'b0;
                    else if (i_state.slot == i2cm_pkg::SLOT_TWO) n_state.clock_level = 1'b1;
                    else n_state.data_level = 1'b1;
                    n_last = (i_state.slot >= i2cm_pkg::SLOT_COND_END);
                end
                i2cm_pkg::OP_WRITE: begin
                    if (i_state.slot == i2cm_pkg::SLOT_FIRST) begin
                        n_state.data_level = 1'b1;
                    end else if (i_state.slot <= i2cm_pkg::SLOT_BITS_END) begin
                        unique case (i_state.phase)
                            i2cm_pkg::PH_FIRST: begin
                                // present next bit, MSB first
                                n_state.data_level = i_state.shift_byte[7];
                                n_state.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                            end
                            i2cm_pkg::PH_SECOND: n_state.clock_level = 1'b1;
                            default:             n_state.clock_level = 1'b0;
                        endcase
                    end else if (i_state.slot == i2cm_pkg::SLOT_RELEASE) begin
                        n_state.data_level = 1'b1;
                    end else if (i_state.slot == i2cm_pkg::SLOT_ACK_A) begin
                        n_state.clock_level = 1'b1;
                        n_state.ack_bit     = i_item.sda_in;
                    end else begin
                        n_state.clock_level = 1'b0;
                    end
                    n_last = (i_state.slot >= i2cm_pkg::SLOT_ACK_B);
                end
                default: begin
                    // read byte
                    if (i_state.slot == i2cm_pkg::SLOT_FIRST) begin
                        n_state.data_level = 1'b1;
                    end else if (i_state.slot <= i2cm_pkg::SLOT_BITS_END) begin
                        if (i_state.phase == i2cm_pkg::PH_FIRST) begin
                            n_state.clock_level = 1'b1;
                            n_state.shift_byte  = {i_state.shift_byte[6:0], i_item.sda_in};
                        end else if (i_state.phase == i2cm_pkg::PH_THIRD) begin
                            n_state.clock_level = 1'b0;
                        end
                    end else if (i_state.slot == i2cm_pkg::SLOT_RELEASE) begin
                        n_state.data_level = 1'b1;
                    end else if (i_state.ack_choice) begin
                        // drive ACK low for one clock
                        if (i_state.slot == i2cm_pkg::SLOT_ACK_A) n_state.data_level = 1'b0;
                        else if (i_state.slot == i2cm_pkg::SLOT_ACK_B) n_state.clock_level = 1'b1;
                        else n_state.clock_level = 1'b0;
                        n_last = (i_state.slot >= i2cm_pkg::SLOT_ACK_C);
                    end else begin
                        // NACK: SDA stays released
                        if (i_state.slot == i2cm_pkg::SLOT_ACK_A) n_state.clock_level = 1'b1;
                        else n_state.clock_level = 1'b0;
                        n_last = (i_state.slot >= i2cm_pkg::SLOT_ACK_B);
                    end
                end
            endcase

            // finish or step to the next slot
            if (n_last) begin
                n_state.active = 1'b0;
                n_done         = 1'b1;
                if (i_state.operation == i2cm_pkg::OP_READ) begin
                    n_state.rx_hold = n_state.shift_byte;
                end
            end else begin
                n_state.slot = i_state.slot + 1'b1;
                if (i_state.slot == i2cm_pkg::SLOT_FIRST ||
                    i_state.phase == i2cm_pkg::PH_THIRD) begin
                    n_state.phase = i2cm_pkg::PH_FIRST;
                end else if (i_state.phase == i2cm_pkg::PH_FIRST) begin
                    n_state.phase = i2cm_pkg::PH_SECOND;
                end else begin
                    n_state.phase = i2cm_pkg::PH_THIRD;
                end
            end
        end
    end

    assign o_state = n_state;

    // result reflects the state after this item
    always_comb begin
        o_res.scl      = n_state.clock_level;
        o_res.sda      = n_state.data_level;
        o_res.busy_res = n_state.active;
        o_res.done_res = n_done;
        o_res.rx_byte  = n_state.rx_hold;
        o_res.ack_seen = n_state.ack_bit;
        o_res.rejected = n_rej;
    end

endmodule

### hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: state register, result register
// and handshakes. Depends on i2cm_pkg, i2cm_if and i2cm_step.
//
//  channel  dir  modport  payload      meaning
//  i_in     in   sink     t_in_item    tick or command item
//  o_out    out  source   t_res_item   pins and status after each item
//
// One result per item, the cycle after acceptance. An item is taken every
// cycle; the only limit is the result register, which frees up in the same
// cycle its item is taken by the sink. Synchronous active-low reset puts the
// pins released, the engine idle and the result register empty. A stall on
// o_out holds the result and stops intake until the sink takes it.
module i2c_master_bit_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cm_in_if.sink            i_in,
    i2cm_res_if.source         o_out
);

    i2cm_pkg::t_state    r_state;
    i2cm_pkg::t_state    n_state;
    i2cm_pkg::t_res_item r_res;
    i2cm_pkg::t_res_item n_res;
    logic                r_out_valid;
    logic                n_accept;

    // intake is open whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign n_accept   = i_in.valid && i_in.ready;

    i2cm_step u_step (
        .i_state (r_state),
        .i_item  (i_in.data),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.operation   <= i2cm_pkg::OP_START;
            r_state.slot        <= i2cm_pkg::SLOT_FIRST;
            r_state.phase       <= i2cm_pkg::PH_FIRST;
            r_state.active      <= 1'b0;
            r_state.shift_byte  <= 8'd0;
            r_state.ack_choice  <= 1'b0;
            r_state.ack_bit     <= 1'b1;
            r_state.clock_level <= 1'b1;
            r_state.data_level  <= 1'b1;
            r_state.rx_hold     <= 8'd0;
        end else if (n_accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_res;

    // a dropped command only happens while a sequence runs
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.rejected) |-> r_res.busy_res)
        else $error("rejected item without busy");

    // completion leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.done_res) |-> (!r_res.busy_res && !r_state.active))
        else $error("done while still busy");

    // slot counter never runs past the longest sequence
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active |-> (r_state.slot <= i2cm_pkg::SLOT_ACK_C))
        else $error("slot index out of range");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled result changed");

endmodule
